>>> hdl/prp_pkg.sv
// Package for the packed record page: sizes, opcodes and status codes.
// Used by the top level of the block and by its checker.
`default_nettype none
package prp_pkg;

    localparam int MAX_SLOTS   = 64;
    localparam int RECORD_BITS = 64;

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W  = SLOT_W + 1;
    localparam int CFG_W  = 7;
    localparam int OP_W   = 2;
    localparam int IDX_W  = 6;
    localparam int RES_W  = 6;
    localparam int DATA_W = 64;
    localparam int ST_W   = 2;

    localparam logic [CFG_W-1:0] SLOT_LIMIT_RST = CFG_W'(64);

    typedef logic [OP_W-1:0] opcode_t;
    typedef logic [ST_W-1:0] status_t;

    localparam opcode_t OP_ADD    = 2'd0;
    localparam opcode_t OP_DELETE = 2'd1;
    localparam opcode_t OP_UPDATE = 2'd2;
    localparam opcode_t OP_READ   = 2'd3;

    localparam status_t ST_OK           = 2'd0;
    localparam status_t ST_NO_SPACE     = 2'd1;
    localparam status_t ST_NOT_FOUND    = 2'd2;
    localparam status_t ST_OUT_OF_RANGE = 2'd3;

endpackage
`default_nettype wire

>>> hdl/prp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module prp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> hdl/packed_record_page_top.sv
// Top level of the packed record page: control sequencer around one record RAM.
// Depends on prp_pkg and prp_ram.
//
// Sequence: add completes in S_EXEC; read goes through S_READ, or ends in S_EXEC when out of range;
// update and delete end in S_EXEC on an empty page, else search from slot 0 in S_SEARCH, which
// reads one slot per cycle (a delete hit before the last slot goes on to S_MOVE to fill the hole).
// Throughput: one item at a time; start is taken at the edge that ends the done cycle.
// Reset clears the count and the slot limit (to 64); RAM contents are not reset.
`default_nettype none
module packed_record_page_top
    import prp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [OP_W-1:0]   opcode,
    input  wire logic [DATA_W-1:0] record_value,
    input  wire logic [DATA_W-1:0] new_value,
    input  wire logic [IDX_W-1:0]  slot_index,
    input  wire logic              cfg_we,
    input  wire logic [CFG_W-1:0]  cfg_wdata,
    output logic                   done,
    output logic [ST_W-1:0]        status,
    output logic [RES_W-1:0]       result_slot,
    output logic [DATA_W-1:0]      read_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_MOVE   = 3'd3;
    localparam logic [2:0] S_READ   = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CFG_W-1:0]       limit_reg;
    logic [SLOT_W-1:0]      ptr_reg, ptr_next;
    opcode_t                op_reg;
    logic [RECORD_BITS-1:0] key_reg, repl_reg;
    logic [IDX_W-1:0]       idx_reg;

    logic                   done_reg, done_next;
    status_t                status_reg, status_next;
    logic [RES_W-1:0]       slot_reg, slot_next;
    logic [DATA_W-1:0]      data_reg, data_next;

    logic                   ram_we;
    logic [SLOT_W-1:0]      ram_waddr, ram_raddr;
    logic [RECORD_BITS-1:0] ram_wdata, ram_rdata;

    logic                   add_ok, read_ok, is_last, has_next;
    logic [SLOT_W-1:0]      last_slot;
    logic [CNT_W-1:0]       ptr_inc;

    prp_ram #(
        .WIDTH (RECORD_BITS),
        .DEPTH (MAX_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign add_ok = ({{CFG_W{1'b0}}, count_reg} < {{CNT_W{1'b0}}, limit_reg})
                    && (count_reg < CNT_W'(MAX_SLOTS));
    assign read_ok   = ({{CNT_W{1'b0}}, idx_reg} < {{IDX_W{1'b0}}, count_reg});
    assign last_slot = SLOT_W'(count_reg - CNT_W'(1));
    assign is_last   = (ptr_reg == last_slot);
    assign ptr_inc   = {1'b0, ptr_reg} + CNT_W'(1);
    assign has_next  = (ptr_inc < count_reg);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        slot_next   = slot_reg;
        data_next   = data_reg;
        ram_we      = 1'b0;
        ram_waddr   = ptr_reg;
        ram_wdata   = repl_reg;
        ram_raddr   = ptr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                status_next = ST_OK;
                slot_next   = '0;
                data_next   = '0;
                unique case (op_reg)
                    OP_ADD:
                    begin
                        state_next = S_IDLE;
                        done_next  = 1'b1;
                        if (add_ok)
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = SLOT_W'(count_reg);
                            ram_wdata  = key_reg;
                            slot_next  = RES_W'(count_reg);
                            count_next = count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            status_next = ST_NO_SPACE;
                        end
                    end
                    OP_READ:
                    begin
                        if (read_ok)
                        begin
                            ram_raddr  = SLOT_W'(idx_reg);
                            state_next = S_READ;
                        end
                        else
                        begin
                            status_next = ST_OUT_OF_RANGE;
                            done_next   = 1'b1;
                            state_next  = S_IDLE;
                        end
                    end
                    default:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_NOT_FOUND;
                            done_next   = 1'b1;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            ptr_next   = '0;
                            ram_raddr  = '0;
                            state_next = S_SEARCH;
                        end
                    end
                endcase
            end
            S_SEARCH:
            begin
                if (ram_rdata == key_reg)
                begin
                    if (op_reg == OP_UPDATE)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = ptr_reg;
                        ram_wdata  = repl_reg;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (is_last)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        slot_next  = RES_W'(ptr_reg);
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ram_raddr  = last_slot;
                        state_next = S_MOVE;
                    end
                end
                else if (has_next)
                begin
                    ptr_next  = SLOT_W'(ptr_inc);
                    ram_raddr = SLOT_W'(ptr_inc);
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_MOVE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = ptr_reg;
                ram_wdata  = ram_rdata;
                count_next = count_reg - CNT_W'(1);
                slot_next  = RES_W'(ptr_reg);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_READ:
            begin
                data_next  = DATA_W'(ram_rdata);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            limit_reg <= SLOT_LIMIT_RST;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
        data_reg   <= data_next;
        if (state_reg == S_IDLE && start)
        begin
            op_reg   <= opcode;
            key_reg  <= record_value[RECORD_BITS-1:0];
            repl_reg <= new_value[RECORD_BITS-1:0];
            idx_reg  <= slot_index;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign result_slot = slot_reg;
    assign read_data   = data_reg;

endmodule
`default_nettype wire

>>> hdl/prp_checker.sv
// Port-level checker for the packed record page, bound to the top level.
// Depends on prp_pkg.
`default_nettype none
module prp_checker
    import prp_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              done,
    input wire logic [ST_W-1:0]   status,
    input wire logic [RES_W-1:0]  result_slot,
    input wire logic [DATA_W-1:0] read_data
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) && !busy))
        else $error("result without a finished item");

    a_busy_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("item finished without a result");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (result_slot == '0 && read_data == '0))
        else $error("failed beat carries slot or data");

endmodule

bind packed_record_page_top prp_checker u_prp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .result_slot (result_slot),
    .read_data   (read_data)
);
`default_nettype wire
